// ----- hw/rtl/wrr_pkg.sv -----
package wrr_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] endpoint_id;
        logic [7:0] weight;
    } wrr_in_t;

    typedef struct packed {
        logic [7:0] chosen_id;
        logic       granted;
        logic [1:0] status;
    } wrr_out_t;

    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_INSERT   = 2'd1;
    localparam logic [1:0] CMD_PICK     = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic clr_step;   // reset one link node (clear sweep)
        logic pick_setup; // resolve cursor, maybe swap lists
        logic pick_take;  // emit pick, decrement credit, maybe unlink
        logic ins_start;  // claim free slot, start walk at a head
        logic walk_step;  // one step of sorted walk
        logic link;       // splice slot at walk position
        logic finish;     // latch result
    } wrr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       zero_w;
        logic       full;
        logic       empty;
        logic       clr_done;
        logic       walk_done;
        logic       need_sort;
    } wrr_stat_t;

endpackage

// ----- hw/rtl/weighted_round_robin_two_list_unit.sv -----
// Weighted round-robin picker with two credit lists.
// Input channel (in_valid/in_ready, in_item): cmd clear, insert or pick.
// Output channel (out_valid/out_ready, out_item): one result per item,
// chosen_id, granted and status.
// One item is in flight at a time; in_ready is high only when idle.
// Each item passes through a decode state. Clear sweeps every link node;
// insert claims a free slot, walks the target list and links the slot;
// pick resolves the cursor and takes the entry, and a pick that drains
// credit also walks the other list and relinks the entry there. The sorted
// walk stops at the list head or at the first node of no greater weight.
// The result holds in an output register until transferred; while the
// receiver stalls, no new input transfer is taken.
// Reset empties both lists, frees all slots, makes the first list the
// consuming one and points the cursor at its head.
module weighted_round_robin_two_list_unit #(
    parameter int MAX_ENDPOINTS = 8,
    parameter int ID_BITS       = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  wrr_pkg::wrr_in_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output wrr_pkg::wrr_out_t out_item
);
    import wrr_pkg::*;

    wrr_cmd_t  ctl;
    wrr_stat_t stat;

    wrr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .ctl(ctl)
    );

    wrr_dp #(.MAX_ENDPOINTS(MAX_ENDPOINTS), .ID_BITS(ID_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_item), .ctl(ctl), .stat(stat), .res(out_item)
    );

    // never accept while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while result pending");

    // a grant always reports ok status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.granted) |-> (out_item.status == ST_OK))
        else $error("grant with error status");

    // controller commands are exclusive where they drive the same links
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.clr_step, ctl.pick_take, ctl.link, ctl.ins_start}))
        else $error("conflicting datapath commands");

endmodule

// ----- hw/rtl/wrr_ctrl.sv -----
module wrr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  wrr_pkg::wrr_stat_t stat,
    output wrr_pkg::wrr_cmd_t  ctl
);
    import wrr_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_CLR   = 8'b0000_0100,
        S_PSET  = 8'b0000_1000,
        S_PTAKE = 8'b0001_0000,
        S_WALK  = 8'b0010_0000,
        S_LINK  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (stat.cmd == CMD_CLEAR)
                    state_next = S_CLR;
                else if (stat.cmd == CMD_INSERT)
                begin
                    if (stat.zero_w || stat.full)
                    begin
                        ctl.finish = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ctl.ins_start = 1'b1;
                        state_next = S_WALK;
                    end
                end
                else if (stat.cmd == CMD_PICK && !stat.empty)
                    state_next = S_PSET;
                else
                begin
                    ctl.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_CLR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_PSET:
            begin
                ctl.pick_setup = 1'b1;
                state_next = S_PTAKE;
            end
            S_PTAKE:
            begin
                ctl.pick_take = 1'b1;
                if (stat.need_sort)
                    state_next = S_WALK;
                else
                begin
                    ctl.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_WALK:
            begin
                if (stat.walk_done)
                    state_next = S_LINK;
                else
                    ctl.walk_step = 1'b1;
            end
            S_LINK:
            begin
                ctl.link = 1'b1;
                ctl.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/wrr_dp.sv -----
module wrr_dp #(
    parameter int MAX_ENDPOINTS = 8,
    parameter int ID_BITS       = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  wrr_pkg::wrr_in_t   in_item,
    input  wrr_pkg::wrr_cmd_t  ctl,
    output wrr_pkg::wrr_stat_t stat,
    output wrr_pkg::wrr_out_t  res
);
    import wrr_pkg::*;

    localparam int NODES = MAX_ENDPOINTS + 2;
    localparam int NW    = $clog2(NODES);
    localparam int SW    = $clog2(MAX_ENDPOINTS);
    localparam logic [NW-1:0] HEAD0 = NW'(MAX_ENDPOINTS);
    localparam logic [NW-1:0] HEAD1 = NW'(MAX_ENDPOINTS + 1);

    // slot payload and links
    logic [ID_BITS-1:0] id_mem [MAX_ENDPOINTS];
    logic [7:0]         wt_mem [MAX_ENDPOINTS];
    logic [7:0]         cr_mem [MAX_ENDPOINTS];
    logic [MAX_ENDPOINTS-1:0] used_reg;
    logic [NW-1:0] nxt_reg [NODES];
    logic [NW-1:0] prv_reg [NODES];
    logic          csel_reg;
    logic [NW-1:0] cur_reg;

    // working registers
    wrr_in_t       item_reg;
    logic [SW-1:0] slot_reg;   // slot being placed / picked
    logic [NW-1:0] head_reg;   // list being walked
    logic [NW-1:0] pre_reg, now_reg;
    logic [NW:0]   guard_reg;
    logic [NW-1:0] p_reg;
    wrr_out_t      res_reg;
    wrr_out_t      res_next;
    logic [NW-1:0] clr_reg;

    logic [NW-1:0] cons_head, sat_head;
    assign cons_head = csel_reg ? HEAD1 : HEAD0;
    assign sat_head  = csel_reg ? HEAD0 : HEAD1;

    // first free slot
    logic [SW-1:0] free_slot;
    logic          full;
    always_comb
    begin
        free_slot = '0;
        full = 1'b1;
        for (int i = MAX_ENDPOINTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SW'(i);
                full = 1'b0;
            end
        end
    end

    function automatic logic is_slot(input logic [NW-1:0] n);
        return n < NW'(MAX_ENDPOINTS);
    endfunction

    // walk termination
    logic walk_done;
    always_comb
    begin
        walk_done = (now_reg == head_reg) || (guard_reg >= (NW+1)'(NODES));
        if (is_slot(now_reg) && wt_mem[slot_reg] >= wt_mem[now_reg[SW-1:0]])
            walk_done = 1'b1;
    end

    // pick cursor resolution
    logic [NW-1:0] p0, p1, pfin;
    logic          do_swap;
    always_comb
    begin
        p0 = cur_reg;
        if (!is_slot(p0) || !used_reg[p0[SW-1:0]])
            p0 = cons_head;
        do_swap = 1'b0;
        pfin = p0;
        if (p0 == cons_head)
        begin
            p1 = nxt_reg[p0];
            pfin = p1;
            if (p1 == cons_head)
            begin
                do_swap = 1'b1;
                pfin = nxt_reg[sat_head];
            end
        end
        else
            p1 = p0;
    end

    logic [SW-1:0] ps;
    logic [7:0]    cr_dec;
    assign ps = p_reg[SW-1:0];
    assign cr_dec = (cr_mem[ps] != 8'd0) ? cr_mem[ps] - 8'd1 : 8'd0;

    // result of the current item
    always_comb
    begin
        res_next = '0;
        if (item_reg.cmd == CMD_INSERT)
        begin
            if (item_reg.weight == 8'd0)
                res_next.status = ST_ZERO;
            else if (full && !ctl.link)
                res_next.status = ST_FULL;
        end
        else if (item_reg.cmd == CMD_PICK)
        begin
            if (used_reg == '0)
                res_next.status = ST_EMPTY;
            else
            begin
                res_next.chosen_id = 8'(id_mem[ctl.pick_take ? ps : slot_reg]);
                res_next.granted   = 1'b1;
            end
        end
    end

    assign stat.cmd       = item_reg.cmd;
    assign stat.zero_w    = (item_reg.weight == 8'd0);
    assign stat.full      = full;
    assign stat.empty     = (used_reg == '0);
    assign stat.clr_done  = (clr_reg == NW'(NODES - 1));
    assign stat.walk_done = walk_done;
    assign stat.need_sort = (cr_dec == 8'd0);
    assign res = res_reg;

    // control-bearing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            csel_reg <= 1'b0;
            cur_reg  <= HEAD0;
            clr_reg  <= '0;
            for (int i = 0; i < NODES; i++)
            begin
                nxt_reg[i] <= NW'(i);
                prv_reg[i] <= NW'(i);
            end
        end
        else
        begin
            if (ctl.load)
                clr_reg <= '0;
            if (ctl.clr_step)
            begin
                nxt_reg[clr_reg] <= clr_reg;
                prv_reg[clr_reg] <= clr_reg;
                clr_reg <= clr_reg + 1'b1;
                used_reg <= '0;
                cur_reg  <= cons_head;
            end
            if (ctl.ins_start)
                used_reg[free_slot] <= 1'b1;
            if (ctl.pick_setup && do_swap)
                csel_reg <= ~csel_reg;
            if (ctl.pick_take)
            begin
                cur_reg <= nxt_reg[p_reg];
                if (cr_dec == 8'd0)
                begin
                    nxt_reg[prv_reg[p_reg]] <= nxt_reg[p_reg];
                    prv_reg[nxt_reg[p_reg]] <= prv_reg[p_reg];
                end
            end
            if (ctl.link)
            begin
                nxt_reg[NW'(slot_reg)] <= now_reg;
                prv_reg[NW'(slot_reg)] <= pre_reg;
                nxt_reg[pre_reg]  <= NW'(slot_reg);
                prv_reg[now_reg]  <= NW'(slot_reg);
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            item_reg <= in_item;
        if (ctl.ins_start)
        begin
            slot_reg <= free_slot;
            id_mem[free_slot] <= ID_BITS'(item_reg.endpoint_id);
            wt_mem[free_slot] <= item_reg.weight;
            head_reg  <= cons_head;
            pre_reg   <= cons_head;
            now_reg   <= nxt_reg[cons_head];
            guard_reg <= '0;
        end
        if (ctl.pick_setup)
            p_reg <= pfin;
        if (ctl.pick_take)
        begin
            cr_mem[ps] <= cr_dec;
            slot_reg  <= ps;
            head_reg  <= sat_head;
            pre_reg   <= sat_head;
            // unlinked node is skipped by walk: start after the splice
            now_reg   <= (nxt_reg[sat_head] == p_reg) ? nxt_reg[p_reg] : nxt_reg[sat_head];
            guard_reg <= '0;
        end
        if (ctl.walk_step)
        begin
            pre_reg   <= now_reg;
            now_reg   <= nxt_reg[now_reg];
            guard_reg <= guard_reg + 1'b1;
        end
        if (ctl.link)
            cr_mem[slot_reg] <= wt_mem[slot_reg];
        if (ctl.finish)
            res_reg <= res_next;
    end

endmodule
